[src/rmct_pkg.sv]
// Shared types and constants for the range max/count tree.
package rmct_pkg;

   localparam int LeafCapacity = 1024;
   localparam int ValueBits    = 32;
   localparam int CountBits    = 11;
   localparam int IndexBits    = 11;
   localparam int NodeCount    = 2 * LeafCapacity - 1;
   localparam int NodeBits     = 11;
   localparam int LeafBase     = LeafCapacity - 1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic [ValueBits-1:0] maximum;
      logic [CountBits-1:0] count;
   } node_type;

   // Combine two (max, count) pairs; equal maxima add their counts.
   function automatic node_type merge_pair(node_type a, node_type b);
      node_type r;
      if (a.maximum < b.maximum) begin
         r = b;
      end else if (a.maximum > b.maximum) begin
         r = a;
      end else begin
         r.maximum = a.maximum;
         r.count   = a.count + b.count;
      end
      return r;
   endfunction

endpackage

[src/range_max_count_tree.sv]
// Top level: segment tree of (max, count) nodes held in one synchronous RAM.
//
// Input beats arrive on req_ (tvalid/tready/tdata/tuser/tlast). tuser is the
// command: 0 loads the next leaf from tdata, 1 runs a range query on the
// half-open leaf range in tdata. tlast on a load beat marks the final leaf
// and starts the rebuild of every inner node.
// A query returns one beat on rsp_ (tdata = maximum, count); a load returns
// nothing.
// A load beat writes its leaf when taken. A query walks up the tree level by
// level (a level check, then a RAM read and merge on the lo side and then on
// the hi side, all on the single RAM read port), then reads the node where the
// sides meet, if any, and merges both sides. An empty or inverted range
// answers in the cycle after its beat. The rebuild after a last load clears
// the unloaded leaves (one a cycle), then merges the 1023 inner nodes.
// After reset the block sweeps all 2047 nodes to zero, one per cycle, and
// accepts no beat until that pass ends.
// One item is handled at a time. A finished query result sits in the output
// register; a stall holds it there while the next item may be accepted,
// but a second query waits until the first result has been taken.
module range_max_count_tree (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: [31:0] leaf_value, [42:32] range_start, [53:43] range_end
   input  logic [55:0] req_tdata,
   // tuser: [0] cmd
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: [31:0] range_maximum, [42:32] maximum_count
   output logic [47:0] rsp_tdata
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FILL, S_BRD_L, S_BRD_R, S_BWR,
      S_QSTEP, S_QRD, S_QMRG, S_QFIN, S_QFRD, S_QOUT
   } state_type;

   localparam int NB = rmct_pkg::NodeBits;
   localparam int VB = rmct_pkg::ValueBits;

   // Node memory
   rmct_pkg::node_type mem [rmct_pkg::NodeCount];
   logic [NB-1:0]      rd_addr;
   rmct_pkg::node_type rd_data_ff;
   logic               wr_en;
   logic [NB-1:0]      wr_addr;
   rmct_pkg::node_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   state_type          state_ff;
   logic [NB-1:0]      ptr_ff;      // clear / fill / build pointer
   logic [NB:0]        load_idx_ff; // next leaf, up to capacity
   rmct_pkg::node_type left_ff;
   logic [NB-1:0]      lo_ff, hi_ff;
   logic               side_ff;     // 0: lo side, 1: hi side this level
   rmct_pkg::node_type lres_ff, rres_ff;
   logic               out_valid_ff;
   rmct_pkg::node_type out_ff;

   logic [VB-1:0] in_value;
   logic [10:0]   in_start, in_end, end_clip;
   assign in_value = req_tdata[31:0];
   assign in_start = req_tdata[42:32];
   assign in_end   = req_tdata[53:43];
   assign end_clip = (in_end > 11'(rmct_pkg::LeafCapacity))
                     ? 11'(rmct_pkg::LeafCapacity) : in_end;

   // Accept only in idle; a query also needs the output register free
   logic accept;
   assign req_tready = (state_ff == S_IDLE) &&
                       (req_tuser == rmct_pkg::CMD_LOAD || !out_valid_ff);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.count, out_ff.maximum};

   // Read address and write port
   always_comb begin
      rd_addr = ptr_ff;
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_IDLE: begin
            if (accept && req_tuser == rmct_pkg::CMD_LOAD &&
                load_idx_ff < (NB+1)'(rmct_pkg::LeafCapacity)) begin
               wr_en   = 1'b1;
               wr_addr = NB'(load_idx_ff) + NB'(rmct_pkg::LeafBase);
               wr_data = '{maximum: in_value, count: 11'd1};
            end
         end
         S_FILL: begin
            wr_en = 1'b1;
         end
         S_BRD_L: rd_addr = NB'({ptr_ff, 1'b1});
         S_BRD_R: rd_addr = NB'({ptr_ff, 1'b0}) + NB'(2);
         S_BWR: begin
            wr_en   = 1'b1;
            wr_data = rmct_pkg::merge_pair(left_ff, rd_data_ff);
         end
         S_QRD:  rd_addr = side_ff ? hi_ff : lo_ff;
         S_QFIN: rd_addr = lo_ff;
         default: ;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         load_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               ptr_ff <= ptr_ff + NB'(1);
               if (ptr_ff == NB'(rmct_pkg::NodeCount - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  if (req_tuser == rmct_pkg::CMD_LOAD) begin
                     logic [NB:0] nidx;
                     nidx = (load_idx_ff < (NB+1)'(rmct_pkg::LeafCapacity))
                            ? load_idx_ff + (NB+1)'(1) : load_idx_ff;
                     if (req_tlast) begin
                        load_idx_ff <= '0;
                        if (nidx < (NB+1)'(rmct_pkg::LeafCapacity)) begin
                           ptr_ff   <= NB'(nidx) + NB'(rmct_pkg::LeafBase);
                           state_ff <= S_FILL;
                        end else begin
                           ptr_ff   <= NB'(rmct_pkg::LeafBase - 1);
                           state_ff <= S_BRD_L;
                        end
                     end else begin
                        load_idx_ff <= nidx;
                     end
                  end else begin
                     lres_ff <= '0;
                     rres_ff <= '0;
                     if (in_start >= end_clip) begin
                        out_ff       <= '0;
                        out_valid_ff <= 1'b1;
                     end else begin
                        lo_ff    <= in_start + NB'(rmct_pkg::LeafBase);
                        hi_ff    <= end_clip - NB'(1) + NB'(rmct_pkg::LeafBase);
                        state_ff <= S_QSTEP;
                     end
                  end
               end
            end
            S_FILL: begin
               if (ptr_ff == NB'(rmct_pkg::NodeCount - 1)) begin
                  ptr_ff   <= NB'(rmct_pkg::LeafBase - 1);
                  state_ff <= S_BRD_L;
               end else begin
                  ptr_ff <= ptr_ff + NB'(1);
               end
            end
            S_BRD_L: state_ff <= S_BRD_R;
            S_BRD_R: begin
               left_ff  <= rd_data_ff;
               state_ff <= S_BWR;
            end
            S_BWR: begin
               if (ptr_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  ptr_ff   <= ptr_ff - NB'(1);
                  state_ff <= S_BRD_L;
               end
            end
            // One level: lo side then hi side
            S_QSTEP: begin
               if (lo_ff < hi_ff) begin
                  side_ff  <= 1'b0;
                  state_ff <= S_QRD;
               end else begin
                  state_ff <= S_QFIN;
               end
            end
            S_QRD: state_ff <= S_QMRG;
            S_QMRG: begin
               if (!side_ff) begin
                  if (lo_ff != '0 && !lo_ff[0]) begin
                     lres_ff <= rmct_pkg::merge_pair(lres_ff, rd_data_ff);
                  end
                  lo_ff    <= lo_ff >> 1; // up_node(lo+1) = lo/2
                  side_ff  <= 1'b1;
                  state_ff <= S_QRD;
               end else begin
                  if (hi_ff[0]) begin
                     rres_ff <= rmct_pkg::merge_pair(rres_ff, rd_data_ff);
                  end
                  hi_ff    <= (hi_ff <= NB'(1)) ? '0 : (hi_ff - NB'(2)) >> 1;
                  state_ff <= S_QSTEP;
               end
            end
            S_QFIN: state_ff <= (lo_ff == hi_ff) ? S_QFRD : S_QOUT;
            S_QFRD: begin
               lres_ff  <= rmct_pkg::merge_pair(lres_ff, rd_data_ff);
               state_ff <= S_QOUT;
            end
            S_QOUT: begin
               out_ff       <= rmct_pkg::merge_pair(lres_ff, rres_ff);
               out_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
